// ===== hdl/vrot_pkg.sv =====
// vrot_pkg: shared types and constants for the vector axis rotator.
// Holds axis/quadrant codes, the CORDIC arctangent table and the gain constant.
// No dependencies.
package vrot_pkg;

  // guard bits carried below the component LSB inside the rotator
  localparam int GUARD = 8;
  // residual angle width (fraction of a turn, 2^32 = full turn)
  localparam int ZW = 32;
  // CORDIC gain compensation, Q31
  localparam int GAIN_W = 31;
  localparam logic [GAIN_W-1:0] GAIN_Q31 = 31'h4DBA76D4;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  // control that travels with every transaction through the pipeline
  typedef struct packed {
    logic  valid;
    axis_t axis;
  } ctl_t;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ZW-1:0] ARC_TAB [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0
  };

  function automatic logic [ZW-1:0] arc_at(input int i);
    logic [4:0] idx;
    idx = i[4:0];
    if (i >= 32) begin
      return '0;
    end
    return ARC_TAB[idx];
  endfunction

endpackage

// ===== hdl/vrot_pre.sv =====
// vrot_pre: input stage. Picks the rotated pair, applies the exact quarter-turn
// pre-rotation and forms the residual angle.
// Depends on vrot_pkg.
module vrot_pre import vrot_pkg::*; #(
  parameter int COMP_WIDTH  = 24,
  parameter int ANGLE_WIDTH = 16,
  parameter int IW          = 35
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         up_ready,
  input  logic [ANGLE_WIDTH-1:0]       angle,
  input  logic [1:0]                   axis_sel,
  input  logic signed [COMP_WIDTH-1:0] vec_x,
  input  logic signed [COMP_WIDTH-1:0] vec_y,
  input  logic signed [COMP_WIDTH-1:0] vec_z,
  input  logic                         dn_ready,
  output ctl_t                         out_ctl,
  output logic signed [IW-1:0]         out_a,
  output logic signed [IW-1:0]         out_b,
  output logic signed [ZW-1:0]         out_z,
  output logic [3*COMP_WIDTH-1:0]      out_side
);

  logic                         en;
  logic [ZW-1:0]                a32;
  logic [ZW-1:0]                a_rnd;
  quad_t                        quad;
  logic [ZW-1:0]                resid;
  logic signed [COMP_WIDTH-1:0] pa;
  logic signed [COMP_WIDTH-1:0] pb;
  logic signed [IW-1:0]         ea;
  logic signed [IW-1:0]         eb;
  axis_t                        axis;

  ctl_t                         ctl_r;
  logic signed [IW-1:0]         a_r, a_nxt;
  logic signed [IW-1:0]         b_r, b_nxt;
  logic signed [ZW-1:0]         z_r;
  logic [3*COMP_WIDTH-1:0]      side_r;

  assign en       = !ctl_r.valid || dn_ready;
  assign up_ready = en;
  assign axis     = axis_t'(axis_sel);

  assign a32   = ZW'(angle) << (ZW - ANGLE_WIDTH);
  assign a_rnd = a32 + (ZW'(1) << (ZW - 3));
  assign quad  = quad_t'(a_rnd[ZW-1:ZW-2]);
  assign resid = a32 - {a_rnd[ZW-1:ZW-2], {(ZW-2){1'b0}}};

  always_comb begin
    case (axis)
      AXIS_X:    begin pa = vec_y; pb = vec_z; end
      AXIS_Y:    begin pa = vec_x; pb = vec_z; end
      AXIS_Z:    begin pa = vec_x; pb = vec_y; end
      AXIS_NONE: begin pa = vec_x; pb = vec_y; end
      default:   begin pa = vec_x; pb = vec_y; end
    endcase
  end

  assign ea = {{(IW-COMP_WIDTH-GUARD){pa[COMP_WIDTH-1]}}, pa, {GUARD{1'b0}}};
  assign eb = {{(IW-COMP_WIDTH-GUARD){pb[COMP_WIDTH-1]}}, pb, {GUARD{1'b0}}};

  always_comb begin
    case (quad)
      QUAD_0:   begin a_nxt = ea;  b_nxt = eb;  end
      QUAD_90:  begin a_nxt = -eb; b_nxt = ea;  end
      QUAD_180: begin a_nxt = -ea; b_nxt = -eb; end
      QUAD_270: begin a_nxt = eb;  b_nxt = -ea; end
      default:  begin a_nxt = ea;  b_nxt = eb;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r.valid <= in_valid;
      ctl_r.axis  <= axis;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      z_r    <= signed'(resid);
      side_r <= {vec_x, vec_y, vec_z};
    end
  end

  assign out_ctl  = ctl_r;
  assign out_a    = a_r;
  assign out_b    = b_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

// ===== hdl/vrot_step.sv =====
// vrot_step: one CORDIC micro-rotation stage (shift-and-add by 2^-STEP).
// Depends on vrot_pkg.
module vrot_step import vrot_pkg::*; #(
  parameter int IW   = 35,
  parameter int SW   = 72,
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 in_ctl,
  input  logic signed [IW-1:0] in_a,
  input  logic signed [IW-1:0] in_b,
  input  logic signed [ZW-1:0] in_z,
  input  logic [SW-1:0]        in_side,
  output logic                 up_ready,
  input  logic                 dn_ready,
  output ctl_t                 out_ctl,
  output logic signed [IW-1:0] out_a,
  output logic signed [IW-1:0] out_b,
  output logic signed [ZW-1:0] out_z,
  output logic [SW-1:0]        out_side
);

  localparam logic signed [ZW-1:0] ARC = signed'(arc_at(STEP));

  logic                 en;
  logic signed [IW-1:0] da;
  logic signed [IW-1:0] db;
  ctl_t                 ctl_r;
  logic signed [IW-1:0] a_r, a_nxt;
  logic signed [IW-1:0] b_r, b_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SW-1:0]        side_r;

  assign en       = !ctl_r.valid || dn_ready;
  assign up_ready = en;

  assign da = in_b >>> STEP;
  assign db = in_a >>> STEP;

  // zero residual counts as positive
  always_comb begin
    if (!in_z[ZW-1]) begin
      a_nxt = in_a - da;
      b_nxt = in_b + db;
      z_nxt = in_z - ARC;
    end else begin
      a_nxt = in_a + da;
      b_nxt = in_b - db;
      z_nxt = in_z + ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_nxt;
      b_r    <= b_nxt;
      z_r    <= z_nxt;
      side_r <= in_side;
    end
  end

  assign out_ctl  = ctl_r;
  assign out_a    = a_r;
  assign out_b    = b_r;
  assign out_z    = z_r;
  assign out_side = side_r;

endmodule

// ===== hdl/vrot_post.sv =====
// vrot_post: gain compensation (split multiply, round), guard-bit drop,
// saturation and result assembly; its last stage is the output register.
// Depends on vrot_pkg.
module vrot_post import vrot_pkg::*; #(
  parameter int COMP_WIDTH = 24,
  parameter int IW         = 35
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctl_t                         in_ctl,
  input  logic signed [IW-1:0]         in_a,
  input  logic signed [IW-1:0]         in_b,
  input  logic [3*COMP_WIDTH-1:0]      in_side,
  output logic                         up_ready,
  input  logic                         dn_ready,
  output logic                         out_valid,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         out_ovf
);

  localparam int SDW = 3 * COMP_WIDTH;
  localparam int LW  = IW / 2;
  localparam int HW  = IW - LW;
  localparam int PLW = LW + GAIN_W;
  localparam int PHW = HW + GAIN_W;
  localparam int SMW = IW + GAIN_W + 1;
  localparam int RW  = SMW - GAIN_W;
  localparam int VW  = RW + 1;
  localparam int TW  = VW - GUARD;
  localparam logic signed [COMP_WIDTH-1:0] CMAX = {1'b0, {(COMP_WIDTH-1){1'b1}}};
  localparam logic signed [COMP_WIDTH-1:0] CMIN = {1'b1, {(COMP_WIDTH-1){1'b0}}};

  // ---------------- stage 1: magnitude and partial products
  logic            en1, en2, en3;
  logic [IW-1:0]   mag_a, mag_b;
  ctl_t            ctl1_r;
  logic [SDW-1:0]  side1_r;
  logic            neg_a1_r, neg_b1_r;
  logic [PLW-1:0]  pl_a_r, pl_b_r;
  logic [PHW-1:0]  ph_a_r, ph_b_r;

  // ---------------- stage 2: rounded product magnitude
  logic [SMW-1:0]  sum_a, sum_b;
  ctl_t            ctl2_r;
  logic [SDW-1:0]  side2_r;
  logic            neg_a2_r, neg_b2_r;
  logic [RW-1:0]   r_a_r, r_b_r;

  // ---------------- stage 3: sign, guard drop, saturate
  logic signed [VW-1:0]         val_a, val_b;
  logic signed [TW-1:0]         t_a, t_b;
  logic signed [COMP_WIDTH-1:0] sat_a, sat_b;
  logic                         ovf_a, ovf_b;
  logic signed [COMP_WIDTH-1:0] raw_x, raw_y, raw_z;
  logic                         v3_r;
  logic signed [COMP_WIDTH-1:0] x_r, x_nxt;
  logic signed [COMP_WIDTH-1:0] y_r, y_nxt;
  logic signed [COMP_WIDTH-1:0] z_r, z_nxt;
  logic                         ovf_r, ovf_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !ctl2_r.valid || en3;
  assign en1      = !ctl1_r.valid || en2;
  assign up_ready = en1;

  assign mag_a = in_a[IW-1] ? IW'(-in_a) : IW'(in_a);
  assign mag_b = in_b[IW-1] ? IW'(-in_b) : IW'(in_b);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      ctl2_r <= '0;
      v3_r   <= 1'b0;
    end else begin
      if (en1) ctl1_r <= in_ctl;
      if (en2) ctl2_r <= ctl1_r;
      if (en3) v3_r   <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      side1_r  <= in_side;
      neg_a1_r <= in_a[IW-1];
      neg_b1_r <= in_b[IW-1];
      pl_a_r   <= PLW'(mag_a[LW-1:0]) * PLW'(GAIN_Q31);
      pl_b_r   <= PLW'(mag_b[LW-1:0]) * PLW'(GAIN_Q31);
      ph_a_r   <= PHW'(mag_a[IW-1:LW]) * PHW'(GAIN_Q31);
      ph_b_r   <= PHW'(mag_b[IW-1:LW]) * PHW'(GAIN_Q31);
    end
  end

  // round half away from zero on the magnitude
  assign sum_a = (SMW'(ph_a_r) << LW) + SMW'(pl_a_r) + (SMW'(1) << (GAIN_W - 1));
  assign sum_b = (SMW'(ph_b_r) << LW) + SMW'(pl_b_r) + (SMW'(1) << (GAIN_W - 1));

  always_ff @(posedge clk) begin
    if (en2) begin
      side2_r  <= side1_r;
      neg_a2_r <= neg_a1_r;
      neg_b2_r <= neg_b1_r;
      r_a_r    <= sum_a[SMW-1:GAIN_W];
      r_b_r    <= sum_b[SMW-1:GAIN_W];
    end
  end

  // -r + 2^(G-1) written as ~r + 2^(G-1) + 1, one adder either way
  assign val_a = signed'(neg_a2_r ? ~{1'b0, r_a_r} : {1'b0, r_a_r})
               + (neg_a2_r ? VW'((1 << (GUARD - 1)) + 1) : VW'(1 << (GUARD - 1)));
  assign val_b = signed'(neg_b2_r ? ~{1'b0, r_b_r} : {1'b0, r_b_r})
               + (neg_b2_r ? VW'((1 << (GUARD - 1)) + 1) : VW'(1 << (GUARD - 1)));
  assign t_a = val_a[VW-1:GUARD];
  assign t_b = val_b[VW-1:GUARD];

  always_comb begin
    ovf_a = !((&t_a[TW-1:COMP_WIDTH-1]) || !(|t_a[TW-1:COMP_WIDTH-1]));
    ovf_b = !((&t_b[TW-1:COMP_WIDTH-1]) || !(|t_b[TW-1:COMP_WIDTH-1]));
    sat_a = ovf_a ? (t_a[TW-1] ? CMIN : CMAX) : t_a[COMP_WIDTH-1:0];
    sat_b = ovf_b ? (t_b[TW-1] ? CMIN : CMAX) : t_b[COMP_WIDTH-1:0];
  end

  assign raw_x = side2_r[SDW-1:2*COMP_WIDTH];
  assign raw_y = side2_r[2*COMP_WIDTH-1:COMP_WIDTH];
  assign raw_z = side2_r[COMP_WIDTH-1:0];

  always_comb begin
    case (ctl2_r.axis)
      AXIS_X: begin
        x_nxt = raw_x; y_nxt = sat_a; z_nxt = sat_b; ovf_nxt = ovf_a || ovf_b;
      end
      AXIS_Y: begin
        x_nxt = sat_a; y_nxt = raw_y; z_nxt = sat_b; ovf_nxt = ovf_a || ovf_b;
      end
      AXIS_Z: begin
        x_nxt = sat_a; y_nxt = sat_b; z_nxt = raw_z; ovf_nxt = ovf_a || ovf_b;
      end
      AXIS_NONE: begin
        x_nxt = raw_x; y_nxt = raw_y; z_nxt = raw_z; ovf_nxt = 1'b0;
      end
      default: begin
        x_nxt = raw_x; y_nxt = raw_y; z_nxt = raw_z; ovf_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_x     = x_r;
  assign out_y     = y_r;
  assign out_z     = z_r;
  assign out_ovf   = ovf_r;

  // pass-through transactions never flag overflow
  a_pass_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (en3 && ctl2_r.valid && ctl2_r.axis == AXIS_NONE) |=> !ovf_r)
    else $error("overflow set on pass-through transaction");

  // a flagged result carries at least one clamped component
  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && ovf_r) |-> (x_r == CMAX || x_r == CMIN || y_r == CMAX ||
                         y_r == CMIN || z_r == CMAX || z_r == CMIN))
    else $error("overflow set but no component at a rail");

  // the output stage only moves when the consumer takes it or it is empty
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !dn_ready) |=> (v3_r && $stable(x_r) && $stable(ovf_r)))
    else $error("output stage changed while held");

endmodule

// ===== hdl/vector_axis_rotator.sv =====
// Channel  | valid      | stall      | payload
// input    | in_valid   | in_stall   | in_angle, in_axis_sel, in_vec_x/y/z
// result   | out_valid  | out_stall  | out_x, out_y, out_z, out_overflow
//
// The pipeline has one pre-rotation stage, one stage per CORDIC micro-rotation and
// three gain/round/saturate stages; one transaction per cycle when not stalled.
// Each stage holds its own valid bit, so bubbles close up under a stall.
// rst_n is synchronous, active low, and clears only the valid bits.
// Top level of the vector axis rotator; depends on vrot_pkg, vrot_pre,
// vrot_step and vrot_post.
module vector_axis_rotator import vrot_pkg::*; #(
  parameter int COMP_WIDTH  = 24,
  parameter int ANGLE_WIDTH = 16,
  parameter int ROT_STEPS   = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ANGLE_WIDTH-1:0]       in_angle,
  input  logic [1:0]                   in_axis_sel,
  input  logic signed [COMP_WIDTH-1:0] in_vec_x,
  input  logic signed [COMP_WIDTH-1:0] in_vec_y,
  input  logic signed [COMP_WIDTH-1:0] in_vec_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] out_x,
  output logic signed [COMP_WIDTH-1:0] out_y,
  output logic signed [COMP_WIDTH-1:0] out_z,
  output logic                         out_overflow
);

  // internal width: guard bits plus headroom for the CORDIC and pair growth
  localparam int IW  = COMP_WIDTH + GUARD + 3;
  localparam int SDW = 3 * COMP_WIDTH;

  ctl_t                 ctl_s  [ROT_STEPS+1];
  logic signed [IW-1:0] a_s    [ROT_STEPS+1];
  logic signed [IW-1:0] b_s    [ROT_STEPS+1];
  logic signed [ZW-1:0] z_s    [ROT_STEPS];
  logic [SDW-1:0]       side_s [ROT_STEPS+1];
  logic                 rdy_s  [ROT_STEPS+2];

  vrot_pre #(
    .COMP_WIDTH  (COMP_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .IW          (IW)
  ) u_pre (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .up_ready (rdy_s[0]),
    .angle    (in_angle),
    .axis_sel (in_axis_sel),
    .vec_x    (in_vec_x),
    .vec_y    (in_vec_y),
    .vec_z    (in_vec_z),
    .dn_ready (rdy_s[1]),
    .out_ctl  (ctl_s[0]),
    .out_a    (a_s[0]),
    .out_b    (b_s[0]),
    .out_z    (z_s[0]),
    .out_side (side_s[0])
  );

  for (genvar k = 0; k < ROT_STEPS; k++) begin : g_step
    if (k < ROT_STEPS - 1) begin : g_mid
      vrot_step #(.IW(IW), .SW(SDW), .STEP(k)) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl_s[k]),
        .in_a     (a_s[k]),
        .in_b     (b_s[k]),
        .in_z     (z_s[k]),
        .in_side  (side_s[k]),
        .up_ready (rdy_s[k+1]),
        .dn_ready (rdy_s[k+2]),
        .out_ctl  (ctl_s[k+1]),
        .out_a    (a_s[k+1]),
        .out_b    (b_s[k+1]),
        .out_z    (z_s[k+1]),
        .out_side (side_s[k+1])
      );
    end else begin : g_last
      // residual angle is spent after the final micro-rotation
      vrot_step #(.IW(IW), .SW(SDW), .STEP(k)) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (ctl_s[k]),
        .in_a     (a_s[k]),
        .in_b     (b_s[k]),
        .in_z     (z_s[k]),
        .in_side  (side_s[k]),
        .up_ready (rdy_s[k+1]),
        .dn_ready (rdy_s[k+2]),
        .out_ctl  (ctl_s[k+1]),
        .out_a    (a_s[k+1]),
        .out_b    (b_s[k+1]),
        .out_z    (),
        .out_side (side_s[k+1])
      );
    end
  end

  vrot_post #(
    .COMP_WIDTH (COMP_WIDTH),
    .IW         (IW)
  ) u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (ctl_s[ROT_STEPS]),
    .in_a      (a_s[ROT_STEPS]),
    .in_b      (b_s[ROT_STEPS]),
    .in_side   (side_s[ROT_STEPS]),
    .up_ready  (rdy_s[ROT_STEPS+1]),
    .dn_ready  (!out_stall),
    .out_valid (out_valid),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z),
    .out_ovf   (out_overflow)
  );

  assign in_stall = !rdy_s[0];

  // a free consumer frees every stage back to the input
  a_free_path: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while result side is free");

  // an empty first stage can always take a transaction
  a_pre_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_s[0].valid |-> !in_stall)
    else $error("input stalled with empty first stage");

  // a transaction entering the pipeline marks the first stage valid
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ctl_s[0].valid)
    else $error("accepted transaction lost at first stage");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for vector_axis_rotator: streams 3-vectors through the
// CORDIC axis rotator and compares each result to a bit-exact fixed-point predictor.
// Depends on vrot_pkg (axis and quadrant codes) and the vector_axis_rotator RTL.
module tb import vrot_pkg::*; ();

  localparam int CW    = 24;
  localparam int AW    = 16;
  localparam int STEPS = 18;

  localparam int     GUARD_BITS  = 8;
  localparam bit [63:0] GAIN_K   = 64'h4DBA76D4;  // Q31 inverse CORDIC gain
  localparam longint COMP_MAX    = 64'sd8388607;
  localparam longint COMP_MIN    = -64'sd8388608;
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] C_ONE = 24'sh100000;  // 1.0 with 20 fraction bits

  localparam int N_RANDOM    = 1428;
  localparam int HOLD_LEN    = 300;
  localparam int HOLD_AFTER  = 400;
  localparam int STALE_LIMIT = 3000;
  localparam int DRAIN       = 50;

  typedef struct packed {
    logic [AW-1:0]        angle;
    axis_t                axis;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_item_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 ovf;
  } rot_out_t;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_stall;
  logic [AW-1:0]        in_angle     = '0;
  logic [1:0]           in_axis_sel  = '0;
  logic signed [CW-1:0] in_vec_x     = '0;
  logic signed [CW-1:0] in_vec_y     = '0;
  logic signed [CW-1:0] in_vec_z     = '0;
  logic                 out_valid;
  logic                 out_stall    = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 out_overflow;

  vec_item_t pending_vecs[$];
  rot_out_t  expected_rots[$];
  vec_item_t cur_vec;

  int snd_wait = 0;
  int snd_calm = 0;
  int rcv_wait = 0;
  int rcv_calm = 0;
  int n_vectors_in   = 0;
  int n_rotations_out = 0;
  int n_passthrough  = 0;
  int n_saturated    = 0;
  int n_mismatch     = 0;
  int n_errors       = 0;
  int n_in_stalled   = 0;
  int seen_in        = 0;
  int hold_cycles    = 0;
  int stale_cycles   = 0;
  bit hold_on        = 1'b0;
  bit hold_done      = 1'b0;

  vector_axis_rotator #(
    .COMP_WIDTH (CW),
    .ANGLE_WIDTH(AW),
    .ROT_STEPS  (STEPS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_angle    (in_angle),
    .in_axis_sel (in_axis_sel),
    .in_vec_x    (in_vec_x),
    .in_vec_y    (in_vec_y),
    .in_vec_z    (in_vec_z),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_overflow(out_overflow)
  );

  always #10 clk = ~clk;

  // atan(2^-i) in 2^-32 turn units
  function automatic longint atan_step(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      default: return 0;
    endcase
  endfunction

  // magnitude times K, rounded half away from zero
  function automatic longint gain_comp(input longint v);
    bit [63:0] mag;
    bit [63:0] hi;
    bit [63:0] lo;
    bit [63:0] r;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    hi  = mag >> 32;
    lo  = {32'd0, mag[31:0]};
    r   = hi * GAIN_K * 2 + ((lo * GAIN_K + 64'h4000_0000) >> 31);
    return (v < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint round_sat(input longint v, inout bit ovf);
    longint r;
    r = (gain_comp(v) + 64'sd128) >>> GUARD_BITS;
    if (r > COMP_MAX) begin
      ovf = 1'b1;
      r = COMP_MAX;
    end else if (r < COMP_MIN) begin
      ovf = 1'b1;
      r = COMP_MIN;
    end
    return r;
  endfunction

  function automatic void turn_pair(input bit [31:0] a32, inout longint pa,
                                    inout longint pb, inout bit ovf);
    bit [31:0] sum;
    bit [31:0] rw;
    quad_t     q;
    longint    z, a, b, t, da, db;
    int        i;
    sum = a32 + 32'h2000_0000;
    q   = quad_t'(sum[31:30]);
    rw  = a32 - {sum[31:30], 30'd0};
    z   = longint'(signed'(rw));
    a   = pa <<< GUARD_BITS;
    b   = pb <<< GUARD_BITS;
    case (q)
      QUAD_90: begin
        t = a;
        a = -b;
        b = t;
      end
      QUAD_180: begin
        a = -a;
        b = -b;
      end
      QUAD_270: begin
        t = a;
        a = b;
        b = -t;
      end
      default: ;
    endcase
    for (i = 0; i < STEPS; i++) begin
      da = b >>> i;
      db = a >>> i;
      if (z >= 0) begin
        a = a - da;
        b = b + db;
        z = z - atan_step(i);
      end else begin
        a = a + da;
        b = b - db;
        z = z + atan_step(i);
      end
    end
    pa = round_sat(a, ovf);
    pb = round_sat(b, ovf);
  endfunction

  function automatic rot_out_t predict_rotation(input vec_item_t it);
    longint   vx, vy, vz;
    bit       ovf;
    bit [31:0] a32;
    rot_out_t p;
    vx  = longint'(signed'(it.x));
    vy  = longint'(signed'(it.y));
    vz  = longint'(signed'(it.z));
    ovf = 1'b0;
    a32 = {it.angle, 16'd0};
    case (it.axis)
      AXIS_X: turn_pair(a32, vy, vz, ovf);
      AXIS_Y: turn_pair(a32, vx, vz, ovf);
      AXIS_Z: turn_pair(a32, vx, vy, ovf);
      default: ;
    endcase
    p.x   = vx[CW-1:0];
    p.y   = vy[CW-1:0];
    p.z   = vz[CW-1:0];
    p.ovf = ovf;
    return p;
  endfunction

  // per-transaction wait 0..9, with occasional runs of back-to-back transactions
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 80);
    return $urandom_range(0, 9);
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return C_MAX - CW'($urandom_range(0, 255));
      1: return C_MIN + CW'($urandom_range(0, 255));
      2: return CW'($urandom_range(0, 2047)) - CW'(1024);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [AW-1:0] rand_angle();
    if ($urandom_range(0, 4) == 0)
      return {3'($urandom_range(0, 7)), 13'd0} + AW'($urandom_range(0, 4)) - 16'd2;
    return AW'($urandom_range(0, 65535));
  endfunction

  task automatic queue_vec(input logic [AW-1:0] angle, input axis_t axis,
                           input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                           input logic signed [CW-1:0] z);
    vec_item_t it;
    it.angle = angle;
    it.axis  = axis;
    it.x     = x;
    it.y     = y;
    it.z     = z;
    pending_vecs.push_back(it);
  endtask

  // driver
  always @(posedge clk) begin
    rot_out_t want;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        want = predict_rotation(cur_vec);
        expected_rots.push_back(want);
        n_vectors_in++;
        if (cur_vec.axis == AXIS_NONE) n_passthrough++;
        if (want.ovf) n_saturated++;
        snd_wait = draw_wait(snd_calm);
      end
      if (!(in_valid && in_stall)) begin
        if (snd_wait > 0) begin
          snd_wait--;
          in_valid <= 1'b0;
        end else if (pending_vecs.size() != 0) begin
          cur_vec = pending_vecs.pop_front();
          in_angle    <= cur_vec.angle;
          in_axis_sel <= cur_vec.axis;
          in_vec_x    <= cur_vec.x;
          in_vec_y    <= cur_vec.y;
          in_vec_z    <= cur_vec.z;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    rot_out_t got;
    rot_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rcv_wait > 0) rcv_wait--;
      if (out_valid && !out_stall) begin
        got.x   = out_x;
        got.y   = out_y;
        got.z   = out_z;
        got.ovf = out_overflow;
        n_rotations_out++;
        if (expected_rots.size() == 0) begin
          n_errors++;
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: x=%0d y=%0d z=%0d ovf=%0b",
                     got.x, got.y, got.z, got.ovf);
        end else begin
          want = expected_rots.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.ovf !== want.ovf) begin
            n_errors++;
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch #%0d: exp x=%0d y=%0d z=%0d ovf=%0b, got x=%0d y=%0d z=%0d ovf=%0b",
                       n_rotations_out, want.x, want.y, want.z, want.ovf,
                       got.x, got.y, got.z, got.ovf);
          end
        end
        rcv_wait = draw_wait(rcv_calm);
      end
      out_stall <= hold_on || (rcv_wait > 0);
    end
  end

  // long receiver hold-off once traffic is flowing, so the pipeline fills up
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) seen_in <= seen_in + 1;
      if (in_valid && in_stall) n_in_stalled <= n_in_stalled + 1;
      if (hold_on) begin
        hold_cycles <= hold_cycles + 1;
        if (hold_cycles == HOLD_LEN - 1) begin
          hold_on   <= 1'b0;
          hold_done <= 1'b1;
        end
      end else if (!hold_done && seen_in >= HOLD_AFTER) begin
        hold_on <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      stale_cycles <= 0;
    else
      stale_cycles <= stale_cycles + 1;
  end

  initial begin : watchdog
    while (stale_cycles < STALE_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", STALE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : main
    int n;
    int n_total;
    // each axis at zero angle, quadrant and octant boundaries
    queue_vec(16'h0000, AXIS_X, C_ONE, 24'sh200000, 24'sh300000);
    queue_vec(16'h0000, AXIS_Y, C_ONE, 24'sh200000, 24'sh300000);
    queue_vec(16'h0000, AXIS_Z, C_ONE, 24'sh200000, 24'sh300000);
    queue_vec(16'h4000, AXIS_Z, C_ONE, 24'sh000000, 24'sh123456);
    queue_vec(16'h8000, AXIS_X, -C_ONE, 24'sh0ABCDE, -24'sh054321);
    queue_vec(16'hC000, AXIS_Y, 24'sh0F0F0F, 24'sh111111, -C_ONE);
    queue_vec(16'hFFFF, AXIS_Z, C_ONE, C_ONE, C_ONE);
    queue_vec(16'h2000, AXIS_Z, C_ONE, 24'sh000000, 24'sh000000);
    queue_vec(16'h1FFF, AXIS_Z, C_ONE, 24'sh000000, 24'sh000000);
    queue_vec(16'h6000, AXIS_X, 24'sh000001, C_ONE, -C_ONE);
    queue_vec(16'hA000, AXIS_Y, C_ONE, 24'sh000002, C_ONE);
    queue_vec(16'hE000, AXIS_Z, -C_ONE, C_ONE, 24'sh000003);
    // saturation in both directions
    queue_vec(16'h2000, AXIS_Z, C_MAX, C_MAX, 24'sh000000);
    queue_vec(16'h8000, AXIS_Z, C_MIN, C_MIN, C_MIN);
    queue_vec(16'h4000, AXIS_X, 24'sh000005, C_MIN, C_MAX);
    queue_vec(16'h8000, AXIS_Y, C_MAX, 24'sh000007, C_MIN);
    queue_vec(16'hC000, AXIS_Z, C_MIN, C_MAX, -24'sh000001);
    queue_vec(16'h0000, AXIS_Z, C_MAX, C_MIN, 24'sh000001);
    // pass-through axis, zero vector, all ones
    queue_vec(16'h0000, AXIS_NONE, C_MAX, C_MIN, C_MAX);
    queue_vec(16'h3039, AXIS_NONE, C_MIN, C_MAX, 24'sh000000);
    queue_vec(16'h0000, AXIS_X, 24'sh000000, 24'sh000000, 24'sh000000);
    queue_vec(16'hFFFF, AXIS_X, -24'sh000001, -24'sh000001, -24'sh000001);
    for (n = 0; n < N_RANDOM; n++)
      queue_vec(rand_angle(), axis_t'($urandom_range(0, 3)),
                rand_comp(), rand_comp(), rand_comp());
    n_total = pending_vecs.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every queued transaction must come back; a lost one trips the watchdog
    while (n_rotations_out < n_total) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("%0d vectors rotated, %0d pass-through, %0d saturated, %0d errors",
             n_vectors_in, n_passthrough, n_saturated, n_errors);
    $display("input held off by the rotator for %0d cycles", n_in_stalled);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
